// ===== rtl/esma_pkg.sv =====
// ============================================================================
// esma_pkg
// Shared constants and types for the encoder speed moving-average unit.
// ============================================================================
package esma_pkg;

    localparam int FILL_W  = 5;
    localparam int RATIO_W = 8;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/esma_cell.sv =====
// ============================================================================
// esma_cell
// One stage of the delta window: holds a delta, shifts it on when enabled.
// ============================================================================
module esma_cell #(
    parameter int WIDTH = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] d_in,
    output logic [WIDTH-1:0] d_out
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

// ===== rtl/esma_div.sv =====
// ============================================================================
// esma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module esma_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic [DIVIDEND_W-1:0]  quotient,
    output esma_pkg::div_status_t  status
);

    import esma_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/encoder_speed_moving_average_unit.sv =====
// ============================================================================
// encoder_speed_moving_average_unit
// Decimated angle-delta moving average with 8-bit fraction output.
// ============================================================================
// Takes one angle beat per s_ handshake. Every cfg-set number of beats the
// wrapped angle change since the last decimated sample is shifted into a row
// of WINDOW delta cells, the running sum is updated and divided by the fill
// count, giving one m_ beat. Beats that do not trigger an output leave the
// unit ready for the next beat; a triggering beat holds s_tready low through
// the ST_START and ST_DIV states while the divider works out one quotient
// bit per cycle. A finished result may wait on m_tready while the next beat
// is already accepted.
module encoder_speed_moving_average_unit #(
    parameter int WINDOW     = 20,
    parameter int ANGLE_BITS = 14,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [esma_pkg::RATIO_W-1:0]             cfg_wr_data,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // angle
    input  logic [((ANGLE_BITS+7)/8)*8-1:0]          s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // speed_avg, window_fill
    output logic [((ANGLE_BITS+FRAC_BITS+esma_pkg::FILL_W+7)/8)*8-1:0] m_tdata
);

    import esma_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = ANGLE_BITS + CNT_W;
    localparam int MAG_W  = SUM_W - 1 + FRAC_BITS;
    localparam int OUT_W  = ANGLE_BITS + FRAC_BITS;
    localparam int MDATA_W = ((OUT_W + FILL_W + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [RATIO_W-1:0]      ratio_reg, ratio_next;
    logic [RATIO_W-1:0]      dec_reg, dec_next, dec_inc;
    logic [ANGLE_BITS-1:0]   prior_reg, prior_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic                    neg_reg, neg_next;
    logic                    mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]        speed_reg, speed_next;
    logic [FILL_W-1:0]       mfill_reg, mfill_next;

    logic [ANGLE_BITS-1:0]   angle;
    logic signed [ANGLE_BITS-1:0] delta;
    logic                    in_beat, fire, slot_free, div_start;
    logic signed [SUM_W-1:0] mag;
    logic [MAG_W-1:0]        dividend, quotient;
    logic [OUT_W-1:0]        quo_trunc;
    div_status_t             div_stat;
    logic [ANGLE_BITS-1:0]   chain [WINDOW];

    assign angle     = s_tdata[ANGLE_BITS-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign dec_inc   = dec_reg + 1'b1;
    assign fire      = in_beat && (dec_inc >= ratio_reg);
    assign delta     = signed'(angle - prior_reg);
    assign slot_free = !mvalid_reg || m_tready;
    assign div_start = (state_reg == ST_START);

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        esma_cell #(
            .WIDTH (ANGLE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (fire),
            .d_in     ((i == 0) ? delta : chain[(i == 0) ? 0 : i-1]),
            .d_out    (chain[i])
        );
    end

    always_comb begin
        mag       = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
        dividend  = MAG_W'(mag[SUM_W-2:0]) << FRAC_BITS;
        quo_trunc = quotient[OUT_W-1:0];
    end

    esma_div #(
        .DIVIDEND_W (MAG_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (fill_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    always_comb begin
        state_next  = state_reg;
        ratio_next  = cfg_wr_en ? cfg_wr_data : ratio_reg;
        dec_next    = dec_reg;
        prior_next  = prior_reg;
        sum_next    = sum_reg;
        fill_next   = fill_reg;
        neg_next    = neg_reg;
        speed_next  = speed_reg;
        mfill_next  = mfill_reg;
        mvalid_next = mvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    dec_next = fire ? '0 : dec_inc;
                end
                if (fire) begin
                    prior_next = angle;
                    sum_next   = sum_reg - SUM_W'(signed'(chain[WINDOW-1]))
                                 + SUM_W'(delta);
                    if (fill_reg < CNT_W'(WINDOW)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_START;
                end
            end
            ST_START: begin
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done && slot_free) begin
                    speed_next  = neg_reg ? -quo_trunc : quo_trunc;
                    mfill_next  = FILL_W'(fill_reg);
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ratio_reg  <= RATIO_RESET;
            dec_reg    <= '0;
            prior_reg  <= '0;
            sum_reg    <= '0;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ratio_reg  <= ratio_next;
            dec_reg    <= dec_next;
            prior_reg  <= prior_next;
            sum_reg    <= sum_next;
            fill_reg   <= fill_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        speed_reg <= speed_next;
        mfill_reg <= mfill_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = MDATA_W'({mfill_reg, speed_reg});

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while accepting beats");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mfill_reg != '0))
        else $error("result beat with empty window");

    a_start_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START) |=> (state_reg == ST_DIV) && div_stat.busy)
        else $error("divider did not start");

endmodule
